>>> design/mce_pkg.sv
// ----------------------------------------------------------------------------
// mce_pkg
// Shared constants and codes for the Montgomery cube exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mce_pkg;

	// words held in each store
	localparam int NUM_WORDS = 64;
	localparam int WORD_W    = 32;
	localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	// longest run in words
	localparam int CAP_WORDS = (NUM_WORDS < 64) ? NUM_WORDS : 64;
	// width of counters that must hold a word count
	localparam int CNT_W     = ((ADDR_W > 7) ? ADDR_W : 7) + 1;

	// stream and register field widths
	localparam int CMD_W     = 2;
	localparam int INDEX_W   = 6;
	localparam int COUNT_W   = 7;
	localparam int CFG_IDX_W = 1;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 40;

	// commands
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_MOD = 2'd0,
		CMD_LOAD_RSQ = 2'd1,
		CMD_LOAD_OPD = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MONT_CONST = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT = 1'd1;

endpackage

`default_nettype wire

>>> design/montgomery_cube_mod_exp.sv
// ----------------------------------------------------------------------------
// montgomery_cube_mod_exp
// Computes a^3 mod n over multi-word operands with word-serial Montgomery
// products on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Write mont_constant (-1/n[0] mod 2^32) and word_count on the cfg port.
//   Load modulus words (cmd 0) and R^2 mod n words (cmd 1) once; they stay.
//   Load operand words (cmd 2); the word with start_flag set starts a run
//   after it is stored. Each load is one input transaction.
//   A run performs three Montgomery products (a*R^2, square, times a), each
//   a sweep over len outer words with len inner words; an inner word reads
//   the stores, multiplies, accumulates, forms the reduction factor (word
//   zero only), multiplies by n and reduces, on the shared multiplier and
//   store read ports. A carry-out correction adds a subtraction pass, and
//   the final compare a pass from the top down, then a subtraction if >= n.
//   Results leave least significant first, each word loaded and held until
//   taken, with tlast on the last word. The input side is not ready during
//   a run. A stalled receiver holds the current result word; the run waits.
//   Reset idles the controller, zeroes mont_constant and sets word_count to
//   one; datapath registers and the stores are not reset and need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module montgomery_cube_mod_exp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input stream
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// word_index[5:0], word_value[37:6], start_flag[38], zero[39]
	input  wire logic [mce_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// cmd[1:0]
	input  wire logic [mce_pkg::CMD_W-1:0]         s_axis_tuser,
	// result stream
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// result_word[31:0], result_index[37:32], zero[39:38]
	output logic      [mce_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                                   m_axis_tlast,
	// configuration writes
	input  wire logic                              cfg_we,
	input  wire logic [mce_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mce_pkg::WORD_W-1:0]        cfg_data
);

	localparam int AW = mce_pkg::ADDR_W;
	localparam int WW = mce_pkg::WORD_W;
	localparam int CW = mce_pkg::CNT_W;

	typedef enum logic [16:0] {
		S_IDLE = 17'h00001,
		S_XRD  = 17'h00002,
		S_XLAT = 17'h00004,
		S_RD   = 17'h00008,
		S_MUL1 = 17'h00010,
		S_ACC  = 17'h00020,
		S_D0   = 17'h00040,
		S_MUL2 = 17'h00080,
		S_RED  = 17'h00100,
		S_TOP  = 17'h00200,
		S_SRD  = 17'h00400,
		S_SUB  = 17'h00800,
		S_CRD  = 17'h01000,
		S_CMP  = 17'h02000,
		S_ORD  = 17'h04000,
		S_OLD  = 17'h08000,
		S_OWT  = 17'h10000
	} state_t;

	state_t state_q;

	logic [WW-1:0]                   mont_q;
	logic [mce_pkg::COUNT_W-1:0]     wcount_q;
	logic [1:0]                      ph_q;
	logic [AW-1:0]                   i_q, j_q, k_q;
	logic [WW-1:0]                   x_q, c_q, n_q, d0_q;
	logic [2*WW-1:0]                 prod_q, acc_q, red_q;
	logic                            borrow_q, sub_final_q;
	logic [WW-1:0]                   out_word_q;
	logic [mce_pkg::INDEX_W-1:0]     out_idx_q;
	logic                            out_last_q, out_valid_q;

	// input fields
	logic [mce_pkg::INDEX_W-1:0] in_index;
	logic [WW-1:0]               in_value;
	logic                        in_start;
	mce_pkg::cmd_t               in_cmd;
	logic                        in_acc;
	logic                        in_fits;
	assign in_index = s_axis_tdata[5:0];
	assign in_value = s_axis_tdata[37:6];
	assign in_start = s_axis_tdata[38];
	assign in_cmd   = mce_pkg::cmd_t'(s_axis_tuser);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign in_fits  = 32'(in_index) < 32'(mce_pkg::NUM_WORDS);

	// active length, clipped to 1..cap
	logic [CW-1:0] len;
	always_comb begin
		if (wcount_q == '0) begin
			len = CW'(1);
		end else if (CW'(wcount_q) > CW'(mce_pkg::CAP_WORDS)) begin
			len = CW'(mce_pkg::CAP_WORDS);
		end else begin
			len = CW'(wcount_q);
		end
	end

	logic i_last, j_last, k_last;
	logic [AW-1:0] len_m1;
	assign i_last = (CW'(i_q) + CW'(1)) == len;
	assign j_last = (CW'(j_q) + CW'(1)) == len;
	assign k_last = (CW'(k_q) + CW'(1)) == len;
	assign len_m1 = AW'(len - CW'(1));

	// store read data
	logic [WW-1:0] mod_rd, rsq_rd, opd_rd, acc_rd, scr_rd;
	logic [AW-1:0] mod_ra, rsq_ra, opd_ra, acc_ra, scr_ra;
	logic [WW-1:0] a_rd, b_rd, c_rd;

	// operand roles per product: a*b into c
	always_comb begin
		case (ph_q)
			2'd0:    begin a_rd = opd_rd; b_rd = rsq_rd; c_rd = scr_rd; end
			2'd1:    begin a_rd = scr_rd; b_rd = scr_rd; c_rd = acc_rd; end
			default: begin a_rd = acc_rd; b_rd = opd_rd; c_rd = scr_rd; end
		endcase
	end

	// read address routing
	always_comb begin
		mod_ra = '0;
		rsq_ra = '0;
		opd_ra = '0;
		acc_ra = '0;
		scr_ra = '0;
		unique case (state_q)
			S_XRD: begin
				case (ph_q)
					2'd0:    opd_ra = i_q;
					2'd1:    scr_ra = i_q;
					default: acc_ra = i_q;
				endcase
			end
			S_RD: begin
				mod_ra = j_q;
				case (ph_q)
					2'd0:    begin rsq_ra = j_q; scr_ra = j_q; end
					2'd1:    begin scr_ra = j_q; acc_ra = j_q; end
					default: begin opd_ra = j_q; scr_ra = j_q; end
				endcase
			end
			S_SRD, S_CRD: begin
				mod_ra = k_q;
				if (ph_q == 2'd1) begin
					acc_ra = k_q;
				end else begin
					scr_ra = k_q;
				end
			end
			S_ORD: scr_ra = k_q;
			default: ;
		endcase
	end

	// shared multiplier
	logic [WW-1:0]   mul_a, mul_b;
	logic [2*WW-1:0] mul_p;
	always_comb begin
		unique case (state_q)
			S_MUL1:  begin mul_a = x_q;          mul_b = b_rd;   end
			S_D0:    begin mul_a = acc_q[WW-1:0]; mul_b = mont_q; end
			default: begin mul_a = d0_q;         mul_b = n_q;    end
		endcase
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// word step sums
	logic [2*WW-1:0] acc_nx, red_nx;
	logic [WW:0]     top, diff;
	assign acc_nx = ((j_q == '0) ? '0 : 64'(acc_q[2*WW-1:WW])) + prod_q + 64'(c_q);
	assign red_nx = ((j_q == '0) ? '0 : 64'(red_q[2*WW-1:WW])) + prod_q + 64'(acc_q[WW-1:0]);
	assign top    = 33'(acc_q[2*WW-1:WW]) + 33'(red_q[2*WW-1:WW]);
	assign diff   = 33'(c_rd) - 33'(mod_rd) - 33'(borrow_q);

	// write port of the product store
	logic          cw_en;
	logic [AW-1:0] cw_addr;
	logic [WW-1:0] cw_data;
	always_comb begin
		cw_en   = 1'b0;
		cw_addr = '0;
		cw_data = '0;
		unique case (state_q)
			S_RED: begin
				cw_en   = (j_q != '0);
				cw_addr = j_q - AW'(1);
				cw_data = red_nx[WW-1:0];
			end
			S_TOP: begin
				cw_en   = 1'b1;
				cw_addr = len_m1;
				cw_data = top[WW-1:0];
			end
			S_SUB: begin
				cw_en   = 1'b1;
				cw_addr = k_q;
				cw_data = diff[WW-1:0];
			end
			default: ;
		endcase
	end

	// load writes into the kept stores
	logic ld_ok;
	assign ld_ok = in_acc && in_fits;

	mce_ram #(.WIDTH(WW), .DEPTH(mce_pkg::NUM_WORDS)) u_mod_ram (
		.clk(clk), .we(ld_ok && in_cmd == mce_pkg::CMD_LOAD_MOD),
		.waddr(AW'(in_index)), .wdata(in_value), .raddr(mod_ra), .rdata(mod_rd)
	);
	mce_ram #(.WIDTH(WW), .DEPTH(mce_pkg::NUM_WORDS)) u_rsq_ram (
		.clk(clk), .we(ld_ok && in_cmd == mce_pkg::CMD_LOAD_RSQ),
		.waddr(AW'(in_index)), .wdata(in_value), .raddr(rsq_ra), .rdata(rsq_rd)
	);
	mce_ram #(.WIDTH(WW), .DEPTH(mce_pkg::NUM_WORDS)) u_opd_ram (
		.clk(clk), .we(ld_ok && in_cmd == mce_pkg::CMD_LOAD_OPD),
		.waddr(AW'(in_index)), .wdata(in_value), .raddr(opd_ra), .rdata(opd_rd)
	);
	mce_ram #(.WIDTH(WW), .DEPTH(mce_pkg::NUM_WORDS)) u_acc_ram (
		.clk(clk), .we(cw_en && ph_q == 2'd1),
		.waddr(cw_addr), .wdata(cw_data), .raddr(acc_ra), .rdata(acc_rd)
	);
	mce_ram #(.WIDTH(WW), .DEPTH(mce_pkg::NUM_WORDS)) u_scr_ram (
		.clk(clk), .we(cw_en && ph_q != 2'd1),
		.waddr(cw_addr), .wdata(cw_data), .raddr(scr_ra), .rdata(scr_rd)
	);

	// where to go once a word step is complete
	state_t step_next;
	assign step_next = (i_last && ph_q == 2'd2) ? S_CRD : S_XRD;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mont_q   <= '0;
			wcount_q <= mce_pkg::COUNT_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == mce_pkg::REG_MONT_CONST) begin
				mont_q <= cfg_data;
			end else begin
				wcount_q <= cfg_data[mce_pkg::COUNT_W-1:0];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			borrow_q    <= 1'b0;
			sub_final_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && in_cmd == mce_pkg::CMD_LOAD_OPD && in_start) begin
						ph_q    <= '0;
						i_q     <= '0;
						state_q <= S_XRD;
					end
				end
				S_XRD:  state_q <= S_XLAT;
				S_XLAT: begin
					j_q     <= '0;
					state_q <= S_RD;
				end
				S_RD:   state_q <= S_MUL1;
				S_MUL1: state_q <= S_ACC;
				S_ACC:  state_q <= (j_q == '0) ? S_D0 : S_MUL2;
				S_D0:   state_q <= S_MUL2;
				S_MUL2: state_q <= S_RED;
				S_RED: begin
					if (j_last) begin
						state_q <= S_TOP;
					end else begin
						j_q     <= j_q + AW'(1);
						state_q <= S_RD;
					end
				end
				S_TOP: begin
					if (top[WW]) begin
						k_q         <= '0;
						borrow_q    <= 1'b0;
						sub_final_q <= 1'b0;
						state_q     <= S_SRD;
					end else begin
						state_q <= step_next;
						if (i_last) begin
							i_q <= '0;
							if (ph_q == 2'd2) begin
								k_q <= len_m1;
							end else begin
								ph_q <= ph_q + 2'd1;
							end
						end else begin
							i_q <= i_q + AW'(1);
						end
					end
				end
				S_SRD:  state_q <= S_SUB;
				S_SUB: begin
					borrow_q <= diff[WW];
					if (!k_last) begin
						k_q     <= k_q + AW'(1);
						state_q <= S_SRD;
					end else if (sub_final_q) begin
						k_q     <= '0;
						state_q <= S_ORD;
					end else begin
						state_q <= step_next;
						if (i_last) begin
							i_q <= '0;
							if (ph_q == 2'd2) begin
								k_q <= len_m1;
							end else begin
								ph_q <= ph_q + 2'd1;
							end
						end else begin
							i_q <= i_q + AW'(1);
						end
					end
				end
				S_CRD:  state_q <= S_CMP;
				// compare from the top word down
				S_CMP: begin
					if (c_rd < mod_rd) begin
						k_q     <= '0;
						state_q <= S_ORD;
					end else if (c_rd > mod_rd || k_q == '0) begin
						k_q         <= '0;
						borrow_q    <= 1'b0;
						sub_final_q <= 1'b1;
						state_q     <= S_SRD;
					end else begin
						k_q     <= k_q - AW'(1);
						state_q <= S_CRD;
					end
				end
				S_ORD:  state_q <= S_OLD;
				S_OLD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OWT;
				end
				S_OWT: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						if (k_last) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_XLAT: x_q <= a_rd;
			S_MUL1: begin
				prod_q <= mul_p;
				// product store reads as zero during the first outer word
				c_q    <= (i_q == '0) ? '0 : c_rd;
				n_q    <= mod_rd;
			end
			S_ACC:  acc_q <= acc_nx;
			S_D0:   d0_q <= mul_p[WW-1:0];
			S_MUL2: prod_q <= mul_p;
			S_RED:  red_q <= red_nx;
			S_OLD: begin
				out_word_q <= scr_rd;
				out_idx_q  <= mce_pkg::INDEX_W'(k_q);
				out_last_q <= k_last;
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_idx_q, out_word_q};
	assign m_axis_tlast  = out_last_q;

	// result valid only while waiting on the receiver
	a_valid_in_owt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> state_q == S_OWT)
		else $error("result valid outside output wait");

	// a loaded word is presented in the next cycle
	a_old_shows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OLD |=> m_axis_tvalid)
		else $error("loaded result not presented");

	// the last result word returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("not idle after last result");

	// input never taken during a run
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid && !cw_en)
		else $error("input ready while busy");

endmodule

`default_nettype wire

>>> design/mce_ram.sv
// ----------------------------------------------------------------------------
// mce_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
